// ----- hdl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants of the Playfair cipher unit
// Letter codes, action codes, sequencer states and key square geometry.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SIDE     = 5;
    localparam int LETTER_W = 5;
    localparam int ALPHABET = 26;

    localparam logic [LETTER_W-1:0] LETTER_I    = LETTER_W'(8);
    localparam logic [LETTER_W-1:0] LETTER_J    = LETTER_W'(9);
    localparam logic [LETTER_W-1:0] LETTER_LAST = LETTER_W'(ALPHABET - 1);
    localparam logic [LETTER_W-1:0] LETTER_END  = LETTER_W'(ALPHABET);

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_KEY     = 2'd1,
        ACT_FILL    = 2'd2,
        ACT_ENCRYPT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOKUP,
        ST_MAP,
        ST_READ,
        ST_EMIT
    } state_t;

endpackage

// ----- hdl/pfc_ram.sv -----
// ----------------------------------------------------------------------------
// pfc_ram: generic RAM, one write port and two registered read ports
// Contents are not reset; a read returns data in the cycle after its address.
// ----------------------------------------------------------------------------
module pfc_ram #(
    parameter int WIDTH = pfc_pkg::LETTER_W,
    parameter int DEPTH = pfc_pkg::ALPHABET
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- hdl/pfc_digraph_map.sv -----
// ----------------------------------------------------------------------------
// pfc_digraph_map: Playfair remap of two square cells
// Splits each cell into row and column, applies the same-row, same-column
// or rectangle rule and returns the two target cells.
// ----------------------------------------------------------------------------
module pfc_digraph_map #(
    parameter int SIDE = pfc_pkg::SIDE
) (
    input  logic [$clog2(SIDE*SIDE)-1:0] cell_a,
    input  logic [$clog2(SIDE*SIDE)-1:0] cell_b,
    output logic [$clog2(SIDE*SIDE)-1:0] new_a,
    output logic [$clog2(SIDE*SIDE)-1:0] new_b
);

    localparam int CW = $clog2(SIDE * SIDE);
    localparam int RW = $clog2(SIDE);
    localparam logic [RW-1:0] EDGE_IDX = RW'(SIDE - 1);

    logic [RW-1:0] row_a;
    logic [RW-1:0] row_b;
    logic [RW-1:0] col_a;
    logic [RW-1:0] col_b;
    logic [RW-1:0] row_a_nx;
    logic [RW-1:0] row_b_nx;
    logic [RW-1:0] col_a_nx;
    logic [RW-1:0] col_b_nx;
    logic [CW-1:0] base_a;
    logic [CW-1:0] base_b;

    // row is the number of row boundaries at or below the cell
    always_comb begin
        row_a = '0;
        row_b = '0;
        for (int k = 1; k < SIDE; k++) begin
            if (cell_a >= CW'(k * SIDE)) begin
                row_a = row_a + 1'b1;
            end
            if (cell_b >= CW'(k * SIDE)) begin
                row_b = row_b + 1'b1;
            end
        end
    end

    assign base_a = CW'(CW'(row_a) * CW'(SIDE));
    assign base_b = CW'(CW'(row_b) * CW'(SIDE));
    assign col_a  = RW'(cell_a - base_a);
    assign col_b  = RW'(cell_b - base_b);

    assign row_a_nx = (row_a == EDGE_IDX) ? '0 : RW'(row_a + 1'b1);
    assign row_b_nx = (row_b == EDGE_IDX) ? '0 : RW'(row_b + 1'b1);
    assign col_a_nx = (col_a == EDGE_IDX) ? '0 : RW'(col_a + 1'b1);
    assign col_b_nx = (col_b == EDGE_IDX) ? '0 : RW'(col_b + 1'b1);

    always_comb begin
        if (row_a == row_b) begin
            new_a = CW'(base_a + CW'(col_a_nx));
            new_b = CW'(base_b + CW'(col_b_nx));
        end else if (col_a == col_b) begin
            new_a = CW'(CW'(row_a_nx) * CW'(SIDE) + CW'(col_a));
            new_b = CW'(CW'(row_b_nx) * CW'(SIDE) + CW'(col_b));
        end else begin
            new_a = CW'(base_a + CW'(col_b));
            new_b = CW'(base_b + CW'(col_a));
        end
    end

endmodule

// ----- hdl/playfair_digraph_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_unit: Playfair key square builder and pair cipher
// Builds a key square from key letters and encrypts letter pairs with it.
// ----------------------------------------------------------------------------
// Input words carry an action and two letters (0=a .. 25=z) on the s_
// channel; result words carry two cipher letters on the m_ channel.
// Clear and add-key-letter give no result.
// Complete walks the alphabet through the single letter placement unit,
// one letter a cycle, and is ready again after the last letter.
// An encrypt on a full square makes one result through cell lookup RAM
// read, remap, key square RAM read and load of the output register; the
// block is ready again the cycle after the load. An encrypt on an
// incomplete square or with an unplaced letter gives no result. s_ready
// is high only while the sequencer is idle.
// The output register holds a result until m_ready; a stalled receiver
// holds an encrypt in its last step, and s_ready stays low until it loads.
// Reset (aresetn low, synchronous) empties the square and drops any
// pending result; RAM contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module playfair_digraph_cipher_unit #(
    parameter int SIDE = pfc_pkg::SIDE
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_action,
    input  logic [pfc_pkg::LETTER_W-1:0] s_letter_a,
    input  logic [pfc_pkg::LETTER_W-1:0] s_letter_b,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pfc_pkg::LETTER_W-1:0] m_cipher_a,
    output logic [pfc_pkg::LETTER_W-1:0] m_cipher_b
);

    localparam int LW    = pfc_pkg::LETTER_W;
    localparam int CELLS = SIDE * SIDE;
    localparam int CW    = $clog2(CELLS);
    localparam int FW    = $clog2(CELLS + 1);
    localparam logic [FW-1:0] FULL = FW'(CELLS);

    pfc_pkg::state_t state_reg, state_next;

    logic [pfc_pkg::ALPHABET-1:0] placed_reg, placed_next;
    logic [FW-1:0]                fill_reg, fill_next;
    logic [LW-1:0]                walk_reg, walk_next;
    logic [LW-1:0]                a_reg, a_next;
    logic [LW-1:0]                b_reg, b_next;
    logic [CW-1:0]                na_reg, na_next;
    logic [CW-1:0]                nb_reg, nb_next;
    logic                         m_valid_reg, m_valid_next;
    logic [LW-1:0]                m_cipher_a_reg, m_cipher_a_next;
    logic [LW-1:0]                m_cipher_b_reg, m_cipher_b_next;

    pfc_pkg::action_t act;
    logic             accept;
    logic [LW-1:0]    cand;
    logic             place_req;
    logic             place_ok;
    logic [LW-1:0]    enc_a;
    logic [LW-1:0]    enc_b;
    logic             enc_ok;
    logic [CW-1:0]    cell_a;
    logic [CW-1:0]    cell_b;
    logic [CW-1:0]    map_a;
    logic [CW-1:0]    map_b;
    logic [LW-1:0]    sq_a;
    logic [LW-1:0]    sq_b;

    assign act    = pfc_pkg::action_t'(s_action);
    assign s_ready = (state_reg == pfc_pkg::ST_IDLE);
    assign accept = s_valid && s_ready;

    // shared placement unit: key letter on accept, alphabet walk in ST_FILL
    assign cand      = (state_reg == pfc_pkg::ST_FILL) ? walk_reg : s_letter_a;
    assign place_req = (state_reg == pfc_pkg::ST_FILL) ||
                       (accept && act == pfc_pkg::ACT_KEY);
    assign place_ok  = place_req && (cand < pfc_pkg::LETTER_END) &&
                       (cand != pfc_pkg::LETTER_J) && !placed_reg[cand] &&
                       (fill_reg < FULL);

    assign enc_a  = (s_letter_a == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : s_letter_a;
    assign enc_b  = (s_letter_b == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : s_letter_b;
    assign enc_ok = (fill_reg == FULL) && (s_letter_a < pfc_pkg::LETTER_END) &&
                    (s_letter_b < pfc_pkg::LETTER_END) &&
                    placed_reg[enc_a] && placed_reg[enc_b];

    pfc_ram #(
        .WIDTH (CW),
        .DEPTH (pfc_pkg::ALPHABET)
    ) u_cell_ram (
        .aclk    (aclk),
        .we      (place_ok),
        .waddr   (cand),
        .wdata   (fill_reg[CW-1:0]),
        .raddr_a (a_reg),
        .raddr_b (b_reg),
        .rdata_a (cell_a),
        .rdata_b (cell_b)
    );

    pfc_digraph_map #(
        .SIDE (SIDE)
    ) u_map (
        .cell_a (cell_a),
        .cell_b (cell_b),
        .new_a  (map_a),
        .new_b  (map_b)
    );

    pfc_ram #(
        .WIDTH (LW),
        .DEPTH (CELLS)
    ) u_square_ram (
        .aclk    (aclk),
        .we      (place_ok),
        .waddr   (fill_reg[CW-1:0]),
        .wdata   (cand),
        .raddr_a (na_reg),
        .raddr_b (nb_reg),
        .rdata_a (sq_a),
        .rdata_b (sq_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfc_pkg::ST_IDLE;
            placed_reg  <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            placed_reg  <= placed_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg       <= walk_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        na_reg         <= na_next;
        nb_reg         <= nb_next;
        m_cipher_a_reg <= m_cipher_a_next;
        m_cipher_b_reg <= m_cipher_b_next;
    end

    always_comb begin
        state_next      = state_reg;
        placed_next     = placed_reg;
        fill_next       = fill_reg;
        walk_next       = walk_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_cipher_a_next = m_cipher_a_reg;
        m_cipher_b_next = m_cipher_b_reg;

        if (place_ok) begin
            placed_next[cand] = 1'b1;
            fill_next         = FW'(fill_reg + 1'b1);
        end

        case (state_reg)
            pfc_pkg::ST_IDLE: begin
                if (accept) begin
                    case (act)
                        pfc_pkg::ACT_CLEAR: begin
                            placed_next = '0;
                            fill_next   = '0;
                        end
                        pfc_pkg::ACT_FILL: begin
                            walk_next  = '0;
                            state_next = pfc_pkg::ST_FILL;
                        end
                        pfc_pkg::ACT_ENCRYPT: begin
                            a_next = enc_a;
                            b_next = enc_b;
                            if (enc_ok) begin
                                state_next = pfc_pkg::ST_LOOKUP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pfc_pkg::ST_FILL: begin
                walk_next = LW'(walk_reg + 1'b1);
                if (walk_reg == pfc_pkg::LETTER_LAST) begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_LOOKUP: begin
                state_next = pfc_pkg::ST_MAP;
            end
            pfc_pkg::ST_MAP: begin
                na_next    = map_a;
                nb_next    = map_b;
                state_next = pfc_pkg::ST_READ;
            end
            pfc_pkg::ST_READ: begin
                state_next = pfc_pkg::ST_EMIT;
            end
            pfc_pkg::ST_EMIT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_cipher_a_next = sq_a;
                    m_cipher_b_next = sq_b;
                    state_next      = pfc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid    = m_valid_reg;
    assign m_cipher_a = m_cipher_a_reg;
    assign m_cipher_b = m_cipher_b_reg;

endmodule
